/* hdl/weighted_histogram_accumulator_core_assert.svh */
// Assertion macros for the weighted histogram accumulator core.
`ifndef WEIGHTED_HISTOGRAM_ACCUMULATOR_CORE_ASSERT_SVH
`define WEIGHTED_HISTOGRAM_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define WHA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wha: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define WHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wha: next-cycle check failed");

`endif

/* hdl/wha_pkg.sv */
// Package for the weighted histogram accumulator: constants, codes and state type.
package wha_pkg;

    localparam int MAX_BINS_DEFAULT = 64;

    localparam int SAMPLE_W = 32;
    localparam int WIDTH_W  = 31;
    localparam int COUNT_W  = 7;
    localparam int INDEX_W  = 6;
    localparam int SUM_W    = 48;
    localparam int LO_W     = 41;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SAMPLE_OOR = 2'd1;
    localparam logic [1:0] STATUS_INDEX_OOR = 2'd2;

    localparam logic MODE_FILL = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 2'd3;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_FETCH = 6'b001000,
        ST_CALC  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

/* hdl/weighted_histogram_accumulator_core.sv */
// Weighted histogram accumulator core: border scan, bin sum memory and stream ports.
// Path: a fill in range scans from bin 0 until its sample lies below a bin's upper border, then
// goes via ST_FETCH and ST_CALC to ST_DONE; an unmatched fill, a rejected sample or a bad read
// index goes to ST_DONE, a good read via ST_FETCH and ST_CALC. ST_DONE waits for a free output.
// One item in work at a time: the border adder/comparer steps once per bin, s_tready low.
// Reset (aresetn low, sync) loads defaults, then clears all MAX_BINS bin sums.
module weighted_histogram_accumulator_core #(
    parameter int MAX_BINS = wha_pkg::MAX_BINS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wha_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // sample_value[31:0], sample_weight[63:32], read_index[69:64]
    input  logic [0:0]  s_tuser,   // mode[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // bin_sum[47:0], bin_hit[53:48]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import wha_pkg::*;

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W = $clog2(MAX_BINS + 1);

    state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] range_min_reg, range_max_reg;
    logic [WIDTH_W-1:0]         bin_width_reg;
    logic [COUNT_W-1:0]         bin_count_reg;

    logic                       mode_reg, mode_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [SAMPLE_W-1:0] w_reg, w_next;
    logic signed [LO_W-1:0]     lo_reg, lo_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;

    logic [1:0]              res_status_reg, res_status_next;
    logic signed [SUM_W-1:0] res_sum_reg, res_sum_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [55:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    logic signed [SUM_W-1:0] mem [MAX_BINS];
    logic signed [SUM_W-1:0] rd_data_reg;
    logic                    mem_we;
    logic signed [SUM_W-1:0] mem_wdata;

    logic [CNT_W-1:0]           n_eff;
    logic signed [LO_W-1:0]     hi;
    logic                       last_bin;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    sum_sat;
    logic                       s_accept;
    logic                       out_free;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic signed [SAMPLE_W-1:0] s_weight;
    logic [INDEX_W-1:0]         s_read_index;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign s_sample     = s_tdata[31:0];
    assign s_weight     = s_tdata[63:32];
    assign s_read_index = s_tdata[69:64];

    assign n_eff = ({25'd0, bin_count_reg} > 32'(MAX_BINS)) ? CNT_W'(MAX_BINS)
                                                             : CNT_W'(bin_count_reg);

    assign hi       = lo_reg + LO_W'({1'b0, bin_width_reg});
    assign last_bin = (32'(idx_reg) + 32'd1) >= 32'(n_eff);

    assign sum_wide = {rd_data_reg[SUM_W-1], rd_data_reg} + (SUM_W + 1)'(w_reg);
    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_CALC && mode_reg == MODE_FILL);
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : sum_sat;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[idx_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_min_reg <= '0;
            range_max_reg <= 32'sd4194304;
            bin_width_reg <= 31'd65536;
            bin_count_reg <= 7'd64;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_RANGE_MIN: range_min_reg <= cfg_data;
                REG_RANGE_MAX: range_max_reg <= cfg_data;
                REG_BIN_WIDTH: bin_width_reg <= cfg_data[WIDTH_W-1:0];
                REG_BIN_COUNT: bin_count_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        x_next          = x_reg;
        w_next          = w_reg;
        lo_next         = lo_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_sum_next    = res_sum_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                if (32'(idx_reg) == 32'(MAX_BINS - 1)) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    mode_next = s_tuser[0];
                    x_next    = s_sample;
                    w_next    = s_weight;
                    lo_next   = LO_W'(range_min_reg);
                    idx_next  = '0;
                    if (s_tuser[0] == MODE_FILL) begin
                        if (s_sample >= range_max_reg || s_sample < range_min_reg
                            || n_eff == '0) begin
                            res_status_next = STATUS_SAMPLE_OOR;
                            res_sum_next    = '0;
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else begin
                        if (32'(s_read_index) >= 32'(n_eff)) begin
                            res_status_next = STATUS_INDEX_OOR;
                            res_sum_next    = '0;
                            state_next      = ST_DONE;
                        end else begin
                            idx_next   = IDX_W'(s_read_index);
                            state_next = ST_FETCH;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (LO_W'(x_reg) < hi) begin
                    state_next = ST_FETCH;
                end else if (last_bin) begin
                    idx_next        = '0;
                    res_status_next = STATUS_SAMPLE_OOR;
                    res_sum_next    = '0;
                    state_next      = ST_DONE;
                end else begin
                    lo_next  = hi;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FETCH: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                res_status_next = STATUS_OK;
                res_sum_next    = (mode_reg == MODE_FILL) ? sum_sat : rd_data_reg;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {2'b00, 6'(idx_reg), res_sum_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        x_reg          <= x_next;
        w_reg          <= w_next;
        lo_reg         <= lo_next;
        res_status_reg <= res_status_next;
        res_sum_reg    <= res_sum_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

`include "weighted_histogram_accumulator_core_assert.svh"

    `WHA_ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_accept, !s_tready)
    `WHA_ASSERT_IMPL(a_reject_zero, aclk, aresetn, m_tvalid && m_tuser != STATUS_OK, m_tdata == '0)
    `WHA_ASSERT_IMPL(a_clear_quiet, aclk, aresetn, state_reg == ST_CLEAR, !s_tready && !m_tvalid)
    `WHA_ASSERT_NEXT(a_done_emits, aclk, aresetn, state_reg == ST_DONE && out_free, m_tvalid && s_tready)

endmodule
